[hw/rtl/ecgi_pkg.sv]
// ----------------------------------------------------------------------------
// ecgi_pkg: shared constants for the ECEF to geodetic converter
// Widths of the shared arithmetic units, register codes and the CORDIC
// arctangent table in units of pi/2^31 rad.
// ----------------------------------------------------------------------------
package ecgi_pkg;

	localparam int MAX_ITER = 12;
	localparam int ITER_W   = $clog2(MAX_ITER + 1);

	localparam int COORD_W = 37;
	localparam int A_W     = 33;
	localparam int E2_W    = 32;
	localparam int MINR_W  = 36;
	localparam int ANG_W   = 32;
	localparam int H_W     = 37;
	localparam int CFG_W   = 36;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECC_SQ     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 2'd2;

	// shared multiplier: 64 x 64, one 16-bit digit of B per cycle
	localparam int MUL_W     = 64;
	localparam int MUL_DIG   = 16;
	localparam int MUL_STEPS = MUL_W / MUL_DIG;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int PROD_W    = 2 * MUL_W;

	// square root: one result bit per cycle
	localparam int SQ_W     = 104;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int SQ_CNT_W = $clog2(ROOT_W);

	// restoring divider: one quotient bit per cycle
	localparam int DVD_W     = 82;
	localparam int DSR_W     = 52;
	localparam int QUO_W     = 52;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam logic [DIV_CNT_W-1:0] SIN_DIV_STEPS = 7'd31;
	localparam logic [DIV_CNT_W-1:0] RAD_DIV_STEPS = 7'd49;

	// CORDIC vectoring
	localparam int CRD_W      = 52;
	localparam int CRD_IW     = CRD_W + 3;
	localparam int CRD_STEPS  = 32;
	localparam int CRD_CNT_W  = $clog2(CRD_STEPS);

	// iteration datapath
	localparam int DZ_W = 51;
	localparam int WV_W = 52;
	localparam int WM_W = 51;

	function automatic logic [ANG_W-1:0] arc_angle(input logic [CRD_CNT_W-1:0] i);
		logic [ANG_W-1:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/ecgi_mul.sv]
// ----------------------------------------------------------------------------
// ecgi_mul: shared unsigned multiplier
// 64 x 64 bit product, one 16-bit digit of the second operand per cycle.
// ----------------------------------------------------------------------------
module ecgi_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ecgi_pkg::MUL_W-1:0]    op_a,
	input  logic [ecgi_pkg::MUL_W-1:0]    op_b,
	output logic                          done,
	output logic [ecgi_pkg::PROD_W-1:0]   prod
);
	import ecgi_pkg::*;

	logic [MUL_W-1:0]         a_q;
	logic [MUL_W-1:0]         b_q;
	logic [PROD_W-1:0]        acc_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [MUL_W+MUL_DIG-1:0] pp;

	assign pp = a_q * b_q[MUL_W-1 -: MUL_DIG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// most significant digit first: shift the sum up, add the next partial product
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << MUL_DIG) + PROD_W'(pp);
			b_q   <= b_q << MUL_DIG;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[hw/rtl/ecgi_sqrt.sv]
// ----------------------------------------------------------------------------
// ecgi_sqrt: integer square root
// Restoring digit-by-digit root, one result bit per cycle, floor result.
// ----------------------------------------------------------------------------
module ecgi_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ecgi_pkg::SQ_W-1:0]    radicand,
	output logic                         done,
	output logic [ecgi_pkg::ROOT_W-1:0]  root
);
	import ecgi_pkg::*;

	logic [SQ_W-1:0]     rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+3:0]   cur;
	logic [ROOT_W+3:0]   trial;
	logic [ROOT_W+3:0]   diff;
	logic                ge;

	assign cur   = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = cur - trial;
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			root_q <= {root_q[ROOT_W-2:0], ge};
			rem_q  <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[hw/rtl/ecgi_div.sv]
// ----------------------------------------------------------------------------
// ecgi_div: restoring divider
// Produces the low 'steps' quotient bits, one per cycle; the upper part of
// the dividend must already be below the divisor.
// ----------------------------------------------------------------------------
module ecgi_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ecgi_pkg::DVD_W-1:0]     dividend,
	input  logic [ecgi_pkg::DSR_W-1:0]     divisor,
	input  logic [ecgi_pkg::DIV_CNT_W-1:0] steps,
	output logic                           done,
	output logic [ecgi_pkg::QUO_W-1:0]     quotient
);
	import ecgi_pkg::*;

	logic [DVD_W-1:0]     dvd_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DSR_W:0]       rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSR_W+1:0]     cur;
	logic [DSR_W+1:0]     diff;
	logic                 ge;
	logic [DVD_W-1:0]     dvd_top;

	assign cur     = {rem_q, dvd_q[cnt_q]};
	assign diff    = cur - {2'b00, dsr_q};
	assign ge      = cur >= {2'b00, dsr_q};
	assign dvd_top = dividend >> steps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps - 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= dvd_top[DSR_W:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W:0] : cur[DSR_W:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/ecgi_cordic.sv]
// ----------------------------------------------------------------------------
// ecgi_cordic: CORDIC vectoring unit
// Angle of (x, y) in units of pi/2^31, 32 iterations, one per cycle.
// ----------------------------------------------------------------------------
module ecgi_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ecgi_pkg::CRD_W-1:0]  vec_y,
	input  logic signed [ecgi_pkg::CRD_W-1:0]  vec_x,
	output logic                               done,
	output logic [ecgi_pkg::ANG_W-1:0]         angle
);
	import ecgi_pkg::*;

	logic signed [CRD_IW-1:0] xv_q;
	logic signed [CRD_IW-1:0] yv_q;
	logic [ANG_W-1:0]         ang_q;
	logic                     zero_q;
	logic [CRD_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [CRD_IW-1:0] dx;
	logic signed [CRD_IW-1:0] dy;
	logic [ANG_W-1:0]         arc;

	assign dx  = yv_q >>> cnt_q;
	assign dy  = xv_q >>> cnt_q;
	assign arc = arc_angle(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CRD_CNT_W'(CRD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (vec_x == '0) && (vec_y == '0);
			// left half plane: rotate by pi first
			if (vec_x < 0) begin
				xv_q  <= -CRD_IW'(vec_x);
				yv_q  <= -CRD_IW'(vec_y);
				ang_q <= 32'h80000000;
			end else begin
				xv_q  <= CRD_IW'(vec_x);
				yv_q  <= CRD_IW'(vec_y);
				ang_q <= '0;
			end
		end else if (busy_q) begin
			if (yv_q < 0) begin
				xv_q  <= xv_q - dx;
				yv_q  <= yv_q + dy;
				ang_q <= ang_q - arc;
			end else begin
				xv_q  <= xv_q + dx;
				yv_q  <= yv_q - dy;
				ang_q <= ang_q + arc;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? '0 : ang_q;

endmodule

[hw/rtl/ecef_to_geodetic_iterative.sv]
// ----------------------------------------------------------------------------
// ecef_to_geodetic_iterative: ECEF position to geodetic latitude/longitude/height
// Sequencer around a shared multiplier, square root, divider and CORDIC unit.
// Setup, then 1 to 12 delta-Z passes through the serial square root and
// divider, then CORDIC; a near-origin item goes out after the radius check.
// One item at a time; in_ready is high only while idle.
// Reset loads the default ellipsoid registers and empties the output register.
// ----------------------------------------------------------------------------
module ecef_to_geodetic_iterative (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ecgi_pkg::COORD_W-1:0]   ecef_x,
	input  logic signed [ecgi_pkg::COORD_W-1:0]   ecef_y,
	input  logic signed [ecgi_pkg::COORD_W-1:0]   ecef_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ecgi_pkg::ANG_W-1:0]     latitude,
	output logic signed [ecgi_pkg::ANG_W-1:0]     longitude,
	output logic signed [ecgi_pkg::H_W-1:0]       height,
	output logic                                  near_origin,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ecgi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ecgi_pkg::CFG_W-1:0]            cfg_data
);
	import ecgi_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_MX, S_MY, S_MZ, S_MR, S_SQP, S_MDZ, S_CHK, S_MW, S_RHO,
		S_S, S_SS, S_T, S_SQ, S_N, S_NE, S_U, S_LAT, S_LON, S_OUT
	} state_t;

	localparam logic signed [ANG_W-1:0] LAT_MAX = 32'sd1073741824;
	localparam logic signed [ANG_W-1:0] LAT_MIN = -32'sd1073741824;
	localparam logic signed [53:0]      H_MAX   = 54'sd68719476735;
	localparam logic signed [53:0]      H_MIN   = -54'sd68719476736;

	state_t state_q;
	logic   issued_q;

	logic [A_W-1:0]    sma_q;
	logic [E2_W-1:0]   e2_q;
	logic [MINR_W-1:0] minr_q;

	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic [73:0]               p2_q;
	logic [73:0]               r2_q;
	logic [36:0]               p_q;
	logic signed [DZ_W-1:0]    dz_q, nxt_q;
	logic signed [WV_W-1:0]    w_q;
	logic [ITER_W-1:0]         iter_q;
	logic                      fin_q;
	logic [100:0]              rad_q;
	logic [ROOT_W-1:0]         rho_q;
	logic [30:0]               s_q;
	logic [60:0]               ss_q;
	logic [60:0]               q_q;
	logic [30:0]               sq_q;
	logic [48:0]               n_q;
	logic [48:0]               u_q;
	logic [ANG_W-1:0]          lat_raw_q;

	logic signed [ANG_W-1:0] res_lat_q, res_lon_q;
	logic signed [H_W-1:0]   res_h_q;
	logic                    res_near_q;
	logic                    out_valid_q;
	logic signed [ANG_W-1:0] lat_o_q, lon_o_q;
	logic signed [H_W-1:0]   h_o_q;
	logic                    near_o_q;

	logic [COORD_W-1:0] mx, my, mz;
	logic [WM_W-1:0]    wm;

	logic                mul_start, mul_done;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [PROD_W-1:0]   prod;
	logic                sq_start, sq_done;
	logic [SQ_W-1:0]     sq_in;
	logic [ROOT_W-1:0]   root;
	logic                div_start, div_done;
	logic [DVD_W-1:0]    div_n;
	logic [DSR_W-1:0]    div_d;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [QUO_W-1:0]    quo;
	logic                crd_start, crd_done;
	logic signed [CRD_W-1:0] crd_y, crd_x;
	logic [ANG_W-1:0]    crd_ang;

	logic [35:0]             dz0_m;
	logic [48:0]             nxt_m;
	logic signed [ANG_W-1:0] lat_s;
	logic signed [ANG_W-1:0] lat_c;
	logic signed [53:0]      h_d;
	logic signed [H_W-1:0]   h_c;

	assign mx = x_q[COORD_W-1] ? COORD_W'(-x_q) : COORD_W'(x_q);
	assign my = y_q[COORD_W-1] ? COORD_W'(-y_q) : COORD_W'(y_q);
	assign mz = z_q[COORD_W-1] ? COORD_W'(-z_q) : COORD_W'(z_q);
	assign wm = w_q[WV_W-1] ? WM_W'(-w_q) : WM_W'(w_q);

	assign dz0_m = prod[67:32];
	assign nxt_m = prod[78:30];

	assign lat_s = signed'(lat_raw_q);
	assign lat_c = (lat_s > LAT_MAX) ? LAT_MAX : ((lat_s < LAT_MIN) ? LAT_MIN : lat_s);
	assign h_d   = signed'({2'b00, rho_q}) - signed'({5'b00000, n_q});
	assign h_c   = (h_d > H_MAX) ? H_MAX[H_W-1:0] :
	               ((h_d < H_MIN) ? H_MIN[H_W-1:0] : h_d[H_W-1:0]);

	// operand selection and unit starts
	always_comb begin
		mul_start = 1'b0;
		sq_start  = 1'b0;
		div_start = 1'b0;
		crd_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		sq_in     = '0;
		div_n     = '0;
		div_d     = '0;
		div_steps = SIN_DIV_STEPS;
		crd_y     = '0;
		crd_x     = '0;
		unique case (state_q)
			S_MX: begin
				mul_a = MUL_W'(mx);
				mul_b = MUL_W'(mx);
			end
			S_MY: begin
				mul_a = MUL_W'(my);
				mul_b = MUL_W'(my);
			end
			S_MZ: begin
				mul_a = MUL_W'(mz);
				mul_b = MUL_W'(mz);
			end
			S_MR: begin
				mul_a = MUL_W'(minr_q);
				mul_b = MUL_W'(minr_q);
			end
			S_MDZ: begin
				mul_a = MUL_W'(mz);
				mul_b = MUL_W'(e2_q);
			end
			S_MW: begin
				mul_a = MUL_W'(wm);
				mul_b = MUL_W'(wm);
			end
			S_SS: begin
				mul_a = MUL_W'(s_q);
				mul_b = MUL_W'(s_q);
			end
			S_T: begin
				mul_a = MUL_W'(e2_q);
				mul_b = MUL_W'(ss_q);
			end
			S_NE: begin
				mul_a = MUL_W'(n_q);
				mul_b = MUL_W'(e2_q);
			end
			S_U: begin
				mul_a = MUL_W'(u_q);
				mul_b = MUL_W'(s_q);
			end
			S_SQP: sq_in = SQ_W'(p2_q);
			S_RHO: sq_in = SQ_W'(rad_q);
			S_SQ:  sq_in = SQ_W'(q_q);
			S_S: begin
				div_n     = DVD_W'({wm, 30'd0});
				div_d     = rho_q;
				div_steps = SIN_DIV_STEPS;
			end
			S_N: begin
				div_n     = DVD_W'({sma_q, 30'd0});
				div_d     = DSR_W'(sq_q);
				div_steps = RAD_DIV_STEPS;
			end
			S_LAT: begin
				crd_y = CRD_W'(w_q);
				crd_x = CRD_W'(p_q);
			end
			S_LON: begin
				crd_y = CRD_W'(y_q);
				crd_x = CRD_W'(x_q);
			end
			default: begin
			end
		endcase
		case (state_q) inside
			S_MX, S_MY, S_MZ, S_MR, S_MDZ, S_MW, S_SS, S_T, S_NE, S_U:
				mul_start = !issued_q;
			S_SQP, S_RHO, S_SQ:
				sq_start = !issued_q;
			S_S, S_N:
				div_start = !issued_q;
			S_LAT, S_LON:
				crd_start = !issued_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
			fin_q       <= 1'b0;
			sma_q       <= 33'd6531212288;
			e2_q        <= 32'd28752143;
			minr_q      <= 36'd1024000000;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SEMI_MAJOR: sma_q  <= cfg_data[A_W-1:0];
					REG_ECC_SQ:     e2_q   <= cfg_data[E2_W-1:0];
					REG_MIN_RADIUS: minr_q <= cfg_data[MINR_W-1:0];
					default: begin
					end
				endcase
			end
			if (mul_start || sq_start || div_start || crd_start)
				issued_q <= 1'b1;
			// the output state reloads the register itself
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q     <= ecef_x;
						y_q     <= ecef_y;
						z_q     <= ecef_z;
						state_q <= S_MX;
					end
				end
				S_MX: begin
					if (mul_done) begin
						p2_q     <= prod[73:0];
						issued_q <= 1'b0;
						state_q  <= S_MY;
					end
				end
				S_MY: begin
					if (mul_done) begin
						p2_q     <= p2_q + prod[73:0];
						issued_q <= 1'b0;
						state_q  <= S_MZ;
					end
				end
				S_MZ: begin
					if (mul_done) begin
						r2_q     <= p2_q + prod[73:0];
						issued_q <= 1'b0;
						state_q  <= S_MR;
					end
				end
				S_MR: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						if (74'(prod[71:0]) > r2_q) begin
							res_lat_q  <= '0;
							res_lon_q  <= '0;
							res_h_q    <= '0;
							res_near_q <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_SQP;
						end
					end
				end
				S_SQP: begin
					if (sq_done) begin
						p_q      <= root[36:0];
						issued_q <= 1'b0;
						state_q  <= S_MDZ;
					end
				end
				S_MDZ: begin
					if (mul_done) begin
						nxt_q    <= z_q[COORD_W-1] ? -DZ_W'(dz0_m) : DZ_W'(dz0_m);
						dz_q     <= '0;
						iter_q   <= '0;
						fin_q    <= 1'b0;
						issued_q <= 1'b0;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					if (iter_q < ITER_W'(MAX_ITER) && dz_q != nxt_q) begin
						dz_q    <= nxt_q;
						w_q     <= WV_W'(z_q) + WV_W'(nxt_q);
						iter_q  <= iter_q + 1'b1;
						state_q <= S_MW;
					end else if (iter_q == '0 && !fin_q) begin
						// no pass ran: evaluate once at the starting delta-Z
						fin_q   <= 1'b1;
						w_q     <= WV_W'(z_q) + WV_W'(dz_q);
						state_q <= S_MW;
					end else begin
						state_q <= S_LAT;
					end
				end
				S_MW: begin
					if (mul_done) begin
						rad_q    <= 101'(p2_q) + prod[100:0];
						issued_q <= 1'b0;
						state_q  <= S_RHO;
					end
				end
				S_RHO: begin
					if (sq_done) begin
						rho_q    <= root;
						issued_q <= 1'b0;
						if (root == '0) begin
							s_q     <= '0;
							state_q <= S_SS;
						end else begin
							state_q <= S_S;
						end
					end
				end
				S_S: begin
					if (div_done) begin
						s_q      <= quo[30:0];
						issued_q <= 1'b0;
						state_q  <= S_SS;
					end
				end
				S_SS: begin
					if (mul_done) begin
						ss_q     <= prod[60:0];
						issued_q <= 1'b0;
						state_q  <= S_T;
					end
				end
				S_T: begin
					if (mul_done) begin
						q_q      <= {1'b1, 60'd0} - {1'b0, prod[91:32]};
						issued_q <= 1'b0;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					if (sq_done) begin
						sq_q     <= root[30:0];
						issued_q <= 1'b0;
						state_q  <= S_N;
					end
				end
				S_N: begin
					if (div_done) begin
						n_q      <= quo[48:0];
						issued_q <= 1'b0;
						state_q  <= fin_q ? S_LAT : S_NE;
					end
				end
				S_NE: begin
					if (mul_done) begin
						u_q      <= prod[80:32];
						issued_q <= 1'b0;
						state_q  <= S_U;
					end
				end
				S_U: begin
					if (mul_done) begin
						nxt_q    <= w_q[WV_W-1] ? -DZ_W'(nxt_m) : DZ_W'(nxt_m);
						issued_q <= 1'b0;
						state_q  <= S_CHK;
					end
				end
				S_LAT: begin
					if (crd_done) begin
						lat_raw_q <= crd_ang;
						issued_q  <= 1'b0;
						state_q   <= S_LON;
					end
				end
				S_LON: begin
					if (crd_done) begin
						res_lat_q  <= lat_c;
						res_lon_q  <= signed'(crd_ang);
						res_h_q    <= h_c;
						res_near_q <= 1'b0;
						issued_q   <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						lat_o_q     <= res_lat_q;
						lon_o_q     <= res_lon_q;
						h_o_q       <= res_h_q;
						near_o_q    <= res_near_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ecgi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	ecgi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (root)
	);

	ecgi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (quo)
	);

	ecgi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crd_start),
		.vec_y  (crd_y),
		.vec_x  (crd_x),
		.done   (crd_done),
		.angle  (crd_ang)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign latitude    = lat_o_q;
	assign longitude   = lon_o_q;
	assign height      = h_o_q;
	assign near_origin = near_o_q;

endmodule

[hw/rtl/ecgi_checker.sv]
// ----------------------------------------------------------------------------
// ecgi_checker: port-level checks for the geodetic converter
// Watches the item channels and the result fields over time.
// ----------------------------------------------------------------------------
module ecgi_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic signed [ecgi_pkg::COORD_W-1:0]   ecef_x,
	input logic signed [ecgi_pkg::COORD_W-1:0]   ecef_y,
	input logic signed [ecgi_pkg::COORD_W-1:0]   ecef_z,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [ecgi_pkg::ANG_W-1:0]     latitude,
	input logic signed [ecgi_pkg::ANG_W-1:0]     longitude,
	input logic signed [ecgi_pkg::H_W-1:0]       height,
	input logic                                  near_origin
);
	import ecgi_pkg::*;

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in work");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(ecef_x) &&
			$stable(ecef_y) && $stable(ecef_z)))
		else $error("waiting input item changed");

	a_near_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && near_origin) |-> (latitude == '0 && longitude == '0 && height == '0))
		else $error("near-origin result carries nonzero fields");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (latitude <= 32'sd1073741824 && latitude >= -32'sd1073741824))
		else $error("latitude beyond a quarter turn");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(latitude) &&
			$stable(longitude) && $stable(height) && $stable(near_origin)))
		else $error("stalled result item changed");

endmodule

bind ecef_to_geodetic_iterative ecgi_checker u_ecgi_checker (.*);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ecef_to_geodetic_iterative
// Drives ECEF positions under several ellipsoid settings, predicts latitude,
// longitude, height and the near-origin flag in fixed point, and compares
// every result in order, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module testbench;
	import ecgi_pkg::*;

	typedef struct {
		logic signed [ANG_W-1:0] lat;
		logic signed [ANG_W-1:0] lon;
		logic signed [H_W-1:0]   hgt;
		logic                    near;
	} geo_fix_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam longint DEF_A    = 64'd6531212288;
	localparam longint DEF_E2   = 64'd28752143;
	localparam longint DEF_MINR = 64'd1024000000;
	localparam int     LIMIT    = 4000000;

	class geo_scoreboard;
		logic [A_W-1:0]    semi_axis;
		logic [E2_W-1:0]   ecc2;
		logic [MINR_W-1:0] min_rad;
		geo_fix_t          fix_q[$];
		int                errors;

		function new();
			semi_axis = A_W'(DEF_A);
			ecc2      = E2_W'(DEF_E2);
			min_rad   = MINR_W'(DEF_MINR);
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_SEMI_MAJOR: semi_axis = d[A_W-1:0];
				REG_ECC_SQ:     ecc2 = d[E2_W-1:0];
				REG_MIN_RADIUS: min_rad = d[MINR_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] root(logic [127:0] n);
			logic [63:0]  r;
			logic [63:0]  c;
			logic [127:0] cc;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				cc = {64'd0, c} * {64'd0, c};
				if (cc <= n)
					r = c;
			end
			return r;
		endfunction

		function logic [31:0] cordic_angle(longint yv, longint xv);
			logic [31:0] z;
			longint      dx, dy;
			z = 0;
			if (xv == 0 && yv == 0)
				return 0;
			if (xv < 0) begin
				xv = -xv;
				yv = -yv;
				z = 32'h80000000;
			end
			for (int i = 0; i < CRD_STEPS; i++) begin
				dx = yv >>> i;
				dy = xv >>> i;
				if (yv < 0) begin
					xv -= dx; yv += dy; z -= arc_angle(i[CRD_CNT_W-1:0]);
				end else begin
					xv += dx; yv -= dy; z += arc_angle(i[CRD_CNT_W-1:0]);
				end
			end
			return z;
		endfunction

		// sine of latitude (Q30 magnitude), rho and prime vertical radius for |w|
		function void radii(input logic [63:0] wm, input logic [127:0] p2,
				output logic [63:0] sv, output logic [63:0] rho, output logic [63:0] nr);
			logic [127:0] t;
			logic [63:0]  ss, q, sq, anum;
			rho = root(p2 + {64'd0, wm} * {64'd0, wm});
			if (rho != 0) begin
				t = ({64'd0, wm} << 30) / {64'd0, rho};
				sv = t[63:0];
			end else
				sv = 0;
			ss = sv * sv;
			t = {96'd0, ecc2} * {64'd0, ss};
			q = (64'd1 << 60) - t[95:32];
			sq = root({64'd0, q});
			anum = {31'd0, semi_axis} << 30;
			nr = anum / sq;
		endfunction

		function void note_position(longint x, longint y, longint z);
			geo_fix_t     e;
			logic [63:0]  mx, my, mz, wm, p, sv, rho, nr, m;
			logic [127:0] p2, r2, t;
			longint       dz, nxt, w, lat, h;
			mx = x < 0 ? -x : x;
			my = y < 0 ? -y : y;
			mz = z < 0 ? -z : z;
			p2 = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
			r2 = p2 + {64'd0, mz} * {64'd0, mz};
			e = '{lat: 0, lon: 0, hgt: 0, near: 1'b1};
			if ({92'd0, min_rad} * {92'd0, min_rad} <= r2) begin
				p = root(p2);
				dz = 0;
				t = {64'd0, mz} * {96'd0, ecc2};
				m = t[95:32];
				nxt = z < 0 ? -longint'(m) : longint'(m);
				for (int i = 0; i < MAX_ITER && dz != nxt; i++) begin
					dz = nxt;
					w = z + dz;
					wm = w < 0 ? -w : w;
					radii(wm, p2, sv, rho, nr);
					t = {64'd0, nr} * {96'd0, ecc2};
					t = {64'd0, t[95:32]} * {64'd0, sv};
					m = t[93:30];
					nxt = w < 0 ? -longint'(m) : longint'(m);
				end
				w = z + dz;
				wm = w < 0 ? -w : w;
				radii(wm, p2, sv, rho, nr);
				lat = longint'($signed(cordic_angle(w, longint'(p))));
				if (lat > (64'sd1 <<< 30)) lat = 64'sd1 <<< 30;
				if (lat < -(64'sd1 <<< 30)) lat = -(64'sd1 <<< 30);
				h = longint'(rho) - longint'(nr);
				if (h > longint'(C_MAX)) h = C_MAX;
				if (h < longint'(C_MIN)) h = C_MIN;
				e.lat = lat[ANG_W-1:0];
				e.lon = cordic_angle(y, x);
				e.hgt = h[H_W-1:0];
				e.near = 1'b0;
			end
			fix_q.push_back(e);
		endfunction

		function void check_fix(geo_fix_t got);
			geo_fix_t e;
			if (fix_q.size() == 0) begin
				$display("%0t: result with nothing pending: lat %0d lon %0d h %0d near %0b",
					$time, got.lat, got.lon, got.hgt, got.near);
				errors++;
				return;
			end
			e = fix_q.pop_front();
			if (got.lat !== e.lat) begin
				$display("%0t: latitude expected %0d actual %0d", $time, e.lat, got.lat);
				errors++;
			end
			if (got.lon !== e.lon) begin
				$display("%0t: longitude expected %0d actual %0d", $time, e.lon, got.lon);
				errors++;
			end
			if (got.hgt !== e.hgt) begin
				$display("%0t: height expected %0d actual %0d", $time, e.hgt, got.hgt);
				errors++;
			end
			if (got.near !== e.near) begin
				$display("%0t: near_origin expected %0b actual %0b", $time, e.near, got.near);
				errors++;
			end
		endfunction

		function int pending();
			return fix_q.size();
		endfunction
	endclass

	logic                        clk, arst_n;
	logic                        in_valid, in_ready, out_valid, out_ready;
	logic signed [COORD_W-1:0]   ecef_x, ecef_y, ecef_z;
	logic signed [ANG_W-1:0]     latitude, longitude;
	logic signed [H_W-1:0]       height;
	logic                        near_origin;
	logic                        cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;

	geo_scoreboard sb = new();
	int   sent, fixes_seen, rx_wait, long_hold, cycles;
	bit   hold_done;

	ecef_to_geodetic_iterative dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random gaps, one long hold-off once the run is under way
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_fix('{lat: latitude, lon: longitude, hgt: height, near: near_origin});
			fixes_seen++;
			rx_wait = ((fixes_seen / 16) % 3 == 0) ? 0 : $urandom_range(0, 11);
			if (fixes_seen == 60 && !hold_done) begin
				long_hold = 6000;
				hold_done = 1;
			end
		end
	end

	always @(negedge clk) begin
		if (long_hold > 0) begin
			out_ready <= 1'b0;
			long_hold--;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else
			out_ready <= 1'b1;
	end

	task automatic send_position(longint x, longint y, longint z);
		int gap;
		gap = ((sent / 20) % 3 == 1) ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ecef_x <= x[COORD_W-1:0];
		ecef_y <= y[COORD_W-1:0];
		ecef_z <= z[COORD_W-1:0];
		do @(posedge clk); while (!in_ready);
		sb.note_position(x, y, z);
		sent++;
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic longint rand_coord(int mode);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case (mode)
			0: return longint'(r[33:0]) - (64'sd1 <<< 33);
			1: return longint'($signed(r[COORD_W-1:0]));
			2: return longint'($urandom_range(0, 2000000000)) - 1000000000;
			default: return 0;
		endcase
	endfunction

	task automatic random_positions(int n);
		int mode;
		longint x, y, z;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			x = rand_coord(mode < 6 ? 0 : mode < 8 ? 1 : 2);
			y = rand_coord(mode < 6 ? 0 : mode < 8 ? 1 : 2);
			z = rand_coord(mode < 6 ? 0 : mode < 8 ? 1 : 2);
			// put some points on an axis plane
			if (mode == 9) begin
				case ($urandom_range(0, 2))
					0: x = 0;
					1: y = 0;
					default: begin x = 0; y = 0; end
				endcase
			end
			send_position(x, y, z);
		end
	endtask

	task automatic set_ellipsoid(longint a, longint e2, longint minr);
		write_cfg(REG_SEMI_MAJOR, CFG_W'(a));
		write_cfg(REG_ECC_SQ, CFG_W'(e2));
		write_cfg(REG_MIN_RADIUS, CFG_W'(minr));
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = REG_SEMI_MAJOR;
		cfg_data = 0;
		ecef_x = 0;
		ecef_y = 0;
		ecef_z = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// default ellipsoid: boundary, axes, quadrants, poles, field extremes
		send_position(0, 0, 0);
		send_position(1023999999, 0, 0);
		send_position(1024000000, 0, 0);
		send_position(DEF_A, 0, 0);
		send_position(-DEF_A, 0, 0);
		send_position(0, DEF_A, 0);
		send_position(0, -DEF_A, 0);
		send_position(-4000000000, -4000000000, 3000000000);
		send_position(0, 0, 6500000000);
		send_position(0, 0, -6500000000);
		send_position(4000000000, 4000000000, 4000000000);
		send_position(C_MAX, C_MAX, C_MAX);
		send_position(C_MIN, C_MIN, C_MIN);
		send_position(C_MAX, 0, C_MIN);
		send_position(C_MIN, C_MAX, 0);
		send_position(-1, C_MAX, -1);
		random_positions(40);
		drain();

		// widest axis, sphere, no radius check: zero vector gives rho of zero
		set_ellipsoid(64'h1_FFFF_FFFF, 0, 0);
		send_position(0, 0, 0);
		send_position(0, 0, 1);
		send_position(C_MIN, 0, 0);
		random_positions(40);
		drain();

		// eccentricity at its top, radius check at its top
		set_ellipsoid(0, 64'hFFFF_FFFF, 64'hF_FFFF_FFFF);
		random_positions(40);
		drain();

		// out-of-range register index is dropped
		write_cfg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
		set_ellipsoid(DEF_A, 64'hFFFF_FFFF, 0);
		send_position(C_MAX, C_MAX, C_MAX);
		send_position(DEF_A / 4, 0, DEF_A / 8);
		random_positions(40);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			set_ellipsoid({$urandom, $urandom} & 64'h1_FFFF_FFFF,
				ph[0] ? $urandom : $urandom_range(0, 64'd100000000),
				ph[1] ? ({$urandom, $urandom} & 64'hF_FFFF_FFFF) :
					$urandom_range(0, 64'd2000000000));
			random_positions(40);
			drain();
		end

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ecgi_pkg.sv
hw/rtl/ecgi_mul.sv
hw/rtl/ecgi_sqrt.sv
hw/rtl/ecgi_div.sv
hw/rtl/ecgi_cordic.sv
hw/rtl/ecef_to_geodetic_iterative.sv
hw/rtl/ecgi_checker.sv
verif/testbench.sv
